>>> design/dphh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dphh_pkg
// Shared codes and constants of the straight-drive controller with heading
// hold: register indexes, operation codes, Q8 gains and fixed limits.
// ----------------------------------------------------------------------------
package dphh_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_TARGET_DISTANCE = 2'd0,
		REG_HEADING_TARGET  = 2'd1,
		REG_SETTLE_TICKS    = 2'd2,
		REG_SETTLE_WINDOW   = 2'd3
	} reg_index_t;

	// operation codes of an input item
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// wheel PID gains, Q8 (0.13, 0.09, 0.3)
	localparam int GAIN_P = 33;
	localparam int GAIN_I = 23;
	localparam int GAIN_D = 77;
	localparam int GAIN_SHIFT = 8;

	// heading PD gains, whole numbers
	localparam int GAIN_HP = 4;
	localparam int GAIN_HD = 6;

	// limits in whole degrees or whole percent
	localparam int INTEG_BAND_DEG  = 150;
	localparam int INTEG_SEED_DEG  = 20;
	localparam int POWER_MAX_PCT   = 90;
	localparam int POWER_MIN_PCT   = 10;
	localparam int RAMP_STEP       = 7;
	localparam int RAMP_MAX        = 2047;
	localparam int MV_PER_PCT      = 110;

	// field and state widths
	localparam int RAMP_WIDTH   = 11;
	localparam int COUNT_WIDTH  = 8;
	localparam int WINDOW_WIDTH = 16;
	localparam int INTEG_WIDTH  = 32;
	localparam int LAST_WIDTH   = 24;
	localparam int DRIVE_WIDTH  = 16;

	localparam logic [COUNT_WIDTH-1:0] SETTLE_TICKS_RESET  = 8'd10;
	localparam logic [WINDOW_WIDTH-1:0] SETTLE_WINDOW_RESET = 16'd16;

endpackage

>>> design/drive_pid_with_heading_hold_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_pid_with_heading_hold_top
// Two-wheel straight-drive PID controller with heading PD correction.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall) takes one item per transfer: a start
//  item (operation 0) clears the move state, a tick item (operation 1)
//  carries both wheel angles and the gyro angle. Every item gives exactly one
//  result on the output channel (out_valid / out_stall): the left and right
//  drive in mV, the move done flag and the saturation flag.
//  An item moves into the input register on its transfer edge, and its
//  result is registered once the result register is free. One item is
//  taken per cycle while the output does not stall; the whole control
//  law for one tick, including the state update, sits between the input
//  register and the result register.
//  A stalled result stays on the output register while one more item waits
//  in the input register; in_stall rises only when both are full.
//  Reset clears the move state, the heading history and both registers, and
//  sets the configuration to target 0, heading 0, 10 settle ticks and a
//  window of 16. Configuration must be written through cfg_write_en, cfg_index
//  and cfg_data while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module drive_pid_with_heading_hold_top #(
	parameter int ANGLE_WIDTH = 20,
	parameter int FRAC_BITS   = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_write_en,
	input  logic [1:0]                    cfg_index,
	input  logic [((ANGLE_WIDTH > dphh_pkg::WINDOW_WIDTH) ?
		ANGLE_WIDTH : dphh_pkg::WINDOW_WIDTH)-1:0] cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic signed [ANGLE_WIDTH-1:0] wheel_a_angle,
	input  logic signed [ANGLE_WIDTH-1:0] wheel_b_angle,
	input  logic signed [ANGLE_WIDTH-1:0] gyro_angle,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [15:0]            left_drive_mv,
	output logic signed [15:0]            right_drive_mv,
	output logic                          move_done,
	output logic                          drive_saturated
);

	localparam int IW  = dphh_pkg::INTEG_WIDTH;
	localparam int LW0 = dphh_pkg::LAST_WIDTH;
	localparam int RW  = dphh_pkg::RAMP_WIDTH;
	localparam int CNW = dphh_pkg::COUNT_WIDTH;
	localparam int WW  = dphh_pkg::WINDOW_WIDTH;
	localparam int OW  = dphh_pkg::DRIVE_WIDTH;

	// error width, difference width and working widths
	localparam int EW   = ANGLE_WIDTH + 1;
	localparam int DW   = ((EW > LW0) ? EW : LW0) + 1;
	localparam int ISW  = ((IW > EW) ? IW : EW) + 1;
	localparam int SUMW = ((DW > IW) ? DW : IW) + 9;
	localparam int PW   = SUMW - dphh_pkg::GAIN_SHIFT;
	localparam int HW   = DW + 4;
	localparam int MW   = ((PW > HW) ? PW : HW) + 1;
	localparam int XW   = MW + 7;
	localparam int LW   = (EW > LW0) ? EW : LW0;
	localparam int CW   = ((EW + 1) > WW) ? (EW + 1) : WW;

	localparam logic signed [SUMW-1:0] BAND_FX =
		SUMW'(dphh_pkg::INTEG_BAND_DEG) <<< FRAC_BITS;
	localparam logic signed [SUMW-1:0] SEED_FX =
		SUMW'(dphh_pkg::INTEG_SEED_DEG) <<< FRAC_BITS;
	localparam logic signed [PW-1:0] PMIN_FX =
		PW'(dphh_pkg::POWER_MIN_PCT) <<< FRAC_BITS;
	localparam logic signed [ISW-1:0] INT_MAX = ISW'(64'sd2147483647);
	localparam logic signed [ISW-1:0] INT_MIN = ISW'(-64'sd2147483648);
	localparam logic signed [LW-1:0] LAST_MAX = LW'(8388607);
	localparam logic signed [LW-1:0] LAST_MIN = LW'(-8388608);
	localparam logic signed [XW-1:0] MV_MAX = XW'(32767);
	localparam logic signed [XW-1:0] MV_MIN = XW'(-32768);

	// configuration registers
	logic signed [ANGLE_WIDTH-1:0] target_q;
	logic signed [ANGLE_WIDTH-1:0] heading_target_q;
	logic [CNW-1:0]                ticks_q;
	logic [WW-1:0]                 window_q;

	// input register
	logic                          valid_s1;
	logic                          op_s1;
	logic signed [ANGLE_WIDTH-1:0] wheel_s1 [2];
	logic signed [ANGLE_WIDTH-1:0] gyro_s1;

	// move state, index 0 is left (wheel a), 1 is right (wheel b)
	logic signed [IW-1:0]  integ_q [2];
	logic signed [LW0-1:0] last_err_q [2];
	logic signed [LW0-1:0] last_he_q;
	logic [RW-1:0]         ramp_q;
	logic [CNW-1:0]        cnt_q [2];

	// result register
	logic                  out_valid_q;
	logic signed [OW-1:0]  left_q;
	logic signed [OW-1:0]  right_q;
	logic                  done_q;
	logic                  sat_q;

	// next-state and result logic
	logic                  advance;
	logic [RW:0]           ramp_sum;
	logic [RW-1:0]         ramp_new;
	logic [RW-1:0]         lim_pct;
	logic signed [PW-1:0]  lim_fx;
	logic signed [EW-1:0]  abs_w [2];
	logic signed [EW-1:0]  err [2];
	logic signed [EW:0]    err_wide [2];
	logic [CW-1:0]         err_mag [2];
	logic signed [ISW-1:0] isum [2];
	logic signed [IW-1:0]  integ_sat [2];
	logic signed [IW-1:0]  integ_new [2];
	logic signed [DW-1:0]  diff [2];
	logic signed [SUMW-1:0] pid_sum [2];
	logic signed [PW-1:0]  pwr_raw [2];
	logic signed [PW-1:0]  pwr_lim [2];
	logic signed [PW-1:0]  pwr [2];
	logic signed [LW-1:0]  err_ext [2];
	logic signed [LW0-1:0] last_err_new [2];
	logic [CNW-1:0]        cnt_new [2];
	logic signed [EW-1:0]  he;
	logic signed [DW-1:0]  hd;
	logic signed [HW-1:0]  heading;
	logic signed [LW-1:0]  he_ext;
	logic signed [LW0-1:0] last_he_new;
	logic signed [MW-1:0]  mix [2];
	logic signed [XW-1:0]  scaled [2];
	logic signed [XW-1:0]  drive [2];
	logic signed [OW-1:0]  drive_sat [2];
	logic                  clip [2];
	logic                  done_new;

	// handshake: result register frees on transfer, input register follows
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q         <= '0;
			heading_target_q <= '0;
			ticks_q          <= dphh_pkg::SETTLE_TICKS_RESET;
			window_q         <= dphh_pkg::SETTLE_WINDOW_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				dphh_pkg::REG_TARGET_DISTANCE: target_q <= cfg_data[ANGLE_WIDTH-1:0];
				dphh_pkg::REG_HEADING_TARGET:  heading_target_q <= cfg_data[ANGLE_WIDTH-1:0];
				dphh_pkg::REG_SETTLE_TICKS:    ticks_q <= cfg_data[CNW-1:0];
				dphh_pkg::REG_SETTLE_WINDOW:   window_q <= cfg_data[WW-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1       <= operation;
			wheel_s1[0] <= wheel_a_angle;
			wheel_s1[1] <= wheel_b_angle;
			gyro_s1     <= gyro_angle;
		end
	end

	// ramp limit grows before use, power cap is the smaller of ramp and max
	always_comb begin
		ramp_sum = {1'b0, ramp_q} + (RW+1)'(dphh_pkg::RAMP_STEP);
		ramp_new = (ramp_sum > (RW+1)'(dphh_pkg::RAMP_MAX)) ?
			RW'(dphh_pkg::RAMP_MAX) : ramp_sum[RW-1:0];
		lim_pct  = (ramp_new < RW'(dphh_pkg::POWER_MAX_PCT)) ?
			ramp_new : RW'(dphh_pkg::POWER_MAX_PCT);
		lim_fx   = $signed(PW'(lim_pct)) <<< FRAC_BITS;
	end

	// heading PD term
	always_comb begin
		he      = EW'(heading_target_q) - EW'(gyro_s1);
		hd      = DW'(he) - DW'(last_he_q);
		heading = HW'(he) * HW'(dphh_pkg::GAIN_HP) + HW'(hd) * HW'(dphh_pkg::GAIN_HD);
		he_ext  = LW'(he);
		if (he_ext > LAST_MAX) begin
			last_he_new = LW0'(LAST_MAX);
		end else if (he_ext < LAST_MIN) begin
			last_he_new = LW0'(LAST_MIN);
		end else begin
			last_he_new = he_ext[LW0-1:0];
		end
	end

	// per wheel PID, clamp, ramp, minimum power, drive and settle count
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			abs_w[i] = (wheel_s1[i] < 0) ? -EW'(wheel_s1[i]) : EW'(wheel_s1[i]);
			err[i]   = EW'(target_q) - abs_w[i];

			// integral with anti-windup band
			isum[i] = ISW'(integ_q[i]) + ISW'(err[i]);
			if (isum[i] > INT_MAX) begin
				integ_sat[i] = IW'(INT_MAX);
			end else if (isum[i] < INT_MIN) begin
				integ_sat[i] = IW'(INT_MIN);
			end else begin
				integ_sat[i] = isum[i][IW-1:0];
			end
			if (SUMW'(err[i]) > BAND_FX) begin
				integ_new[i] = '0;
			end else if (SUMW'(err[i]) < BAND_FX && SUMW'(err[i]) > -BAND_FX) begin
				integ_new[i] = IW'(SEED_FX);
			end else begin
				integ_new[i] = integ_sat[i];
			end

			diff[i]    = DW'(err[i]) - DW'(last_err_q[i]);
			pid_sum[i] = SUMW'(err[i]) * SUMW'(dphh_pkg::GAIN_P)
				+ SUMW'(integ_new[i]) * SUMW'(dphh_pkg::GAIN_I)
				+ SUMW'(diff[i]) * SUMW'(dphh_pkg::GAIN_D);
			pwr_raw[i] = $signed(pid_sum[i][SUMW-1:dphh_pkg::GAIN_SHIFT]);
			pwr_lim[i] = (pwr_raw[i] > lim_fx) ? lim_fx : pwr_raw[i];
			pwr[i]     = (pwr_lim[i] < PMIN_FX && pwr_lim[i] > -PMIN_FX) ?
				PMIN_FX : pwr_lim[i];

			// stored error
			err_ext[i] = LW'(err[i]);
			if (err_ext[i] > LAST_MAX) begin
				last_err_new[i] = LW0'(LAST_MAX);
			end else if (err_ext[i] < LAST_MIN) begin
				last_err_new[i] = LW0'(LAST_MIN);
			end else begin
				last_err_new[i] = err_ext[i][LW0-1:0];
			end

			// settle counter
			err_wide[i] = (EW+1)'(err[i]);
			err_mag[i]  = CW'(unsigned'((err_wide[i] < 0) ? -err_wide[i] : err_wide[i]));
			if (err_mag[i] < CW'(window_q)) begin
				cnt_new[i] = (cnt_q[i] == '1) ? cnt_q[i] : cnt_q[i] + CNW'(1);
			end else begin
				cnt_new[i] = '0;
			end

			// drive in mV: left adds heading, right subtracts it
			mix[i]    = (i == 0) ? MW'(pwr[i]) + MW'(heading) : MW'(pwr[i]) - MW'(heading);
			scaled[i] = XW'(mix[i]) * XW'(dphh_pkg::MV_PER_PCT);
			drive[i]  = scaled[i] >>> FRAC_BITS;
			clip[i]   = (drive[i] > MV_MAX) || (drive[i] < MV_MIN);
			if (drive[i] > MV_MAX) begin
				drive_sat[i] = OW'(MV_MAX);
			end else if (drive[i] < MV_MIN) begin
				drive_sat[i] = OW'(MV_MIN);
			end else begin
				drive_sat[i] = drive[i][OW-1:0];
			end
		end
		done_new = (cnt_new[0] >= ticks_q) && (cnt_new[1] >= ticks_q);
	end

	// move state update, once per item leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q[0]    <= '0;
			integ_q[1]    <= '0;
			last_err_q[0] <= '0;
			last_err_q[1] <= '0;
			last_he_q     <= '0;
			ramp_q        <= '0;
			cnt_q[0]      <= '0;
			cnt_q[1]      <= '0;
		end else if (advance && valid_s1) begin
			if (op_s1 == dphh_pkg::OP_START) begin
				integ_q[0]    <= '0;
				integ_q[1]    <= '0;
				last_err_q[0] <= '0;
				last_err_q[1] <= '0;
				ramp_q        <= '0;
				cnt_q[0]      <= '0;
				cnt_q[1]      <= '0;
			end else begin
				integ_q[0]    <= integ_new[0];
				integ_q[1]    <= integ_new[1];
				last_err_q[0] <= last_err_new[0];
				last_err_q[1] <= last_err_new[1];
				last_he_q     <= last_he_new;
				ramp_q        <= ramp_new;
				cnt_q[0]      <= cnt_new[0];
				cnt_q[1]      <= cnt_new[1];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			if (op_s1 == dphh_pkg::OP_START) begin
				left_q  <= '0;
				right_q <= '0;
				done_q  <= 1'b0;
				sat_q   <= 1'b0;
			end else begin
				left_q  <= drive_sat[0];
				right_q <= drive_sat[1];
				done_q  <= done_new;
				sat_q   <= clip[0] || clip[1];
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign left_drive_mv   = left_q;
	assign right_drive_mv  = right_q;
	assign move_done       = done_q;
	assign drive_saturated = sat_q;

	// input side stalls only with an item held in the input register
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall raised with empty input register");

	// a start item clears the ramp and both settle counters
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && op_s1 == dphh_pkg::OP_START) |=>
		(ramp_q == '0 && cnt_q[0] == '0 && cnt_q[1] == '0))
		else $error("start item did not clear move state");

	// a shown done flag agrees with the settle counters
	a_done_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> (cnt_q[0] >= ticks_q && cnt_q[1] >= ticks_q))
		else $error("move_done without both counters at threshold");

	// a saturation flag comes with a drive value at a rail
	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && sat_q) |->
		(left_q == 16'sh7fff || left_q == -16'sh8000 ||
		right_q == 16'sh7fff || right_q == -16'sh8000))
		else $error("drive_saturated without a clipped drive value");

endmodule

>>> tb/sv/drive_pid_with_heading_hold_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_pid_with_heading_hold_top_test
// Self-checking bench for the straight-drive controller with heading hold.
// A directed table covers reset, extreme angles, the integral band edges,
// the settle window edge and a zero settle threshold. Random moves follow:
// mostly well-formed approaches to the target, with some noise ticks and
// broken moves, over several register settings. Every result is checked
// against a control-law model or a table value, with random idling on both
// channels, one long output hold-off and one stretch without idling.
// ----------------------------------------------------------------------------
module drive_pid_with_heading_hold_top_test;

	localparam int ANGLE_W = 20;
	localparam int FRAC = 4;
	localparam int ITEM_GOAL = 400;
	localparam int HOLD_CYCLES = 64;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               done;
		logic               sat;
	} drive_result_t;

	typedef struct {
		bit                         is_cfg;
		dphh_pkg::reg_index_t       idx;
		logic [ANGLE_W-1:0]         data;
		logic                       op;
		logic signed [ANGLE_W-1:0]  a;
		logic signed [ANGLE_W-1:0]  b;
		logic signed [ANGLE_W-1:0]  g;
		bit                         typed;
		drive_result_t              res;
	} row_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        cfg_write_en = 1'b0;
	logic [1:0]                  cfg_index = dphh_pkg::REG_TARGET_DISTANCE;
	logic [ANGLE_W-1:0]          cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic                        operation = dphh_pkg::OP_START;
	logic signed [ANGLE_W-1:0]   wheel_a_angle = '0;
	logic signed [ANGLE_W-1:0]   wheel_b_angle = '0;
	logic signed [ANGLE_W-1:0]   gyro_angle = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [15:0]          left_drive_mv;
	logic signed [15:0]          right_drive_mv;
	logic                        move_done;
	logic                        drive_saturated;

	drive_pid_with_heading_hold_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.wheel_a_angle(wheel_a_angle),
		.wheel_b_angle(wheel_b_angle),
		.gyro_angle(gyro_angle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_drive_mv(left_drive_mv),
		.right_drive_mv(right_drive_mv),
		.move_done(move_done),
		.drive_saturated(drive_saturated)
	);

	// register copies as the block sees them
	longint tgt_val = 0;
	longint head_val = 0;
	int     ticks_val = dphh_pkg::SETTLE_TICKS_RESET;
	int     window_val = dphh_pkg::SETTLE_WINDOW_RESET;

	// controller state copy
	longint integ_l = 0, integ_r = 0;
	longint last_l = 0, last_r = 0, last_he = 0;
	int     ramp = 0;
	int     cnt_l = 0, cnt_r = 0;

	drive_result_t pending_drives[$];

	// run control and bookkeeping
	bit send_calm = 0;
	bit recv_calm = 0;
	bit hold_armed = 0;
	int hold_count = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	int ticks_sent = 0, starts_sent = 0;
	int results_checked = 0, done_seen = 0, sat_seen = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint mag(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic longint clip(input longint x, input longint lo, input longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	function automatic logic signed [ANGLE_W-1:0] to_angle(input longint x);
		return ANGLE_W'(clip(x, -64'sd524288, 64'sd524287));
	endfunction

	task automatic clear_move_state();
		integ_l = 0;
		integ_r = 0;
		last_l = 0;
		last_r = 0;
		ramp = 0;
		cnt_l = 0;
		cnt_r = 0;
	endtask

	// one wheel: integral with band rules, PID in Q8, clamp, ramp and floor
	task automatic wheel_power(input longint e, inout longint integ, inout longint last,
			output longint p);
		longint band, one;
		band = longint'(dphh_pkg::INTEG_BAND_DEG) << FRAC;
		one = longint'(1) << FRAC;
		integ = clip(integ + e, -64'sd2147483648, 64'sd2147483647);
		if (e > band)
			integ = 0;
		if (mag(e) < band)
			integ = longint'(dphh_pkg::INTEG_SEED_DEG) << FRAC;
		p = (dphh_pkg::GAIN_P * e + dphh_pkg::GAIN_I * integ
			+ dphh_pkg::GAIN_D * (e - last)) >>> dphh_pkg::GAIN_SHIFT;
		if (p > dphh_pkg::POWER_MAX_PCT * one)
			p = dphh_pkg::POWER_MAX_PCT * one;
		if (p > ramp * one)
			p = ramp * one;
		if (mag(p) < dphh_pkg::POWER_MIN_PCT * one)
			p = dphh_pkg::POWER_MIN_PCT * one;
		last = clip(e, -64'sd8388608, 64'sd8388607);
	endtask

	function automatic int settle_next(input int c, input longint e);
		if (mag(e) < longint'(window_val))
			return (c < 255) ? c + 1 : 255;
		return 0;
	endfunction

	// drive values for one item, advancing the state copy
	task automatic compute_drive(input logic op, input longint wa, input longint wb,
			input longint g, output drive_result_t res);
		longint el, er, he, heading, pl, pr, l, r;
		res = '0;
		if (op == dphh_pkg::OP_START) begin
			clear_move_state();
		end else begin
			ramp = (ramp + dphh_pkg::RAMP_STEP > dphh_pkg::RAMP_MAX) ?
				dphh_pkg::RAMP_MAX : ramp + dphh_pkg::RAMP_STEP;
			el = tgt_val - mag(wa);
			er = tgt_val - mag(wb);
			he = head_val - g;
			heading = dphh_pkg::GAIN_HP * he + dphh_pkg::GAIN_HD * (he - last_he);
			wheel_power(er, integ_r, last_r, pr);
			wheel_power(el, integ_l, last_l, pl);
			last_he = clip(he, -64'sd8388608, 64'sd8388607);
			l = (dphh_pkg::MV_PER_PCT * (pl + heading)) >>> FRAC;
			r = (dphh_pkg::MV_PER_PCT * (pr - heading)) >>> FRAC;
			res.sat = (l > 32767 || l < -32768 || r > 32767 || r < -32768);
			res.left = 16'(clip(l, -64'sd32768, 64'sd32767));
			res.right = 16'(clip(r, -64'sd32768, 64'sd32767));
			cnt_r = settle_next(cnt_r, er);
			cnt_l = settle_next(cnt_l, el);
			res.done = (cnt_l >= ticks_val) && (cnt_r >= ticks_val);
		end
	endtask

	// offer one item, idling first at random, and log its expected drive
	task automatic send_item(input logic op, input logic signed [ANGLE_W-1:0] a,
			input logic signed [ANGLE_W-1:0] b, input logic signed [ANGLE_W-1:0] g,
			input bit typed, input drive_result_t typed_res);
		drive_result_t res;
		if (!send_calm && int'($urandom_range(0, 99)) < 38) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while (!send_calm && int'($urandom_range(0, 99)) < 38);
		end
		in_valid <= 1'b1;
		operation <= op;
		wheel_a_angle <= a;
		wheel_b_angle <= b;
		gyro_angle <= g;
		do
			@(posedge clk);
		while (in_stall);
		compute_drive(op, a, b, g, res);
		pending_drives.push_back(typed ? typed_res : res);
		if (op == dphh_pkg::OP_START)
			starts_sent++;
		else
			ticks_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input dphh_pkg::reg_index_t idx, input logic [ANGLE_W-1:0] val);
		wait_idle();
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			dphh_pkg::REG_TARGET_DISTANCE: tgt_val = $signed(val);
			dphh_pkg::REG_HEADING_TARGET:  head_val = $signed(val);
			dphh_pkg::REG_SETTLE_TICKS:    ticks_val = val[7:0];
			dphh_pkg::REG_SETTLE_WINDOW:   window_val = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [ANGLE_W-1:0] tv, input logic [ANGLE_W-1:0] hv,
			input logic [ANGLE_W-1:0] kv, input logic [ANGLE_W-1:0] wv);
		write_reg(dphh_pkg::REG_TARGET_DISTANCE, tv);
		write_reg(dphh_pkg::REG_HEADING_TARGET, hv);
		write_reg(dphh_pkg::REG_SETTLE_TICKS, kv);
		write_reg(dphh_pkg::REG_SETTLE_WINDOW, wv);
	endtask

	// a move: start, then wheels closing on the target, some noise and breaks
	task automatic run_move(input int len);
		int k, span, pa, pb, roll;
		drive_result_t none;
		none = '0;
		span = (tgt_val > 0) ? int'(tgt_val) : 0;
		send_item(dphh_pkg::OP_START, ANGLE_W'($urandom), ANGLE_W'($urandom),
			ANGLE_W'($urandom), 0, none);
		for (k = 1; k <= len; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				send_item(dphh_pkg::OP_START, ANGLE_W'($urandom), ANGLE_W'($urandom),
					ANGLE_W'($urandom), 0, none);
			end else if (roll < 9) begin
				send_item(dphh_pkg::OP_TICK, ANGLE_W'($urandom), ANGLE_W'($urandom),
					ANGLE_W'($urandom), 0, none);
			end else begin
				if (tgt_val > 0)
					pa = (k > len - 12) ? span : int'((longint'(span) * k) / len);
				else
					pa = $urandom_range(0, 200);
				pb = pa + int'($urandom_range(0, 16)) - 8;
				pa = pa + int'($urandom_range(0, 16)) - 8;
				send_item(dphh_pkg::OP_TICK,
					to_angle($urandom_range(0, 1) ? -pa : pa),
					to_angle($urandom_range(0, 1) ? -pb : pb),
					to_angle(head_val + int'($urandom_range(0, 64)) - 32), 0, none);
			end
		end
	endtask

	function automatic row_t item_row(input logic op, input logic signed [ANGLE_W-1:0] a,
			input logic signed [ANGLE_W-1:0] b, input logic signed [ANGLE_W-1:0] g);
		row_t r;
		r = '{idx: dphh_pkg::REG_TARGET_DISTANCE, default: '0};
		r.op = op;
		r.a = a;
		r.b = b;
		r.g = g;
		return r;
	endfunction

	function automatic row_t known_row(input logic op, input logic signed [ANGLE_W-1:0] a,
			input logic signed [ANGLE_W-1:0] b, input logic signed [ANGLE_W-1:0] g,
			input logic signed [15:0] l, input logic signed [15:0] rr,
			input logic d, input logic s);
		row_t r;
		r = item_row(op, a, b, g);
		r.typed = 1;
		r.res.left = l;
		r.res.right = rr;
		r.res.done = d;
		r.res.sat = s;
		return r;
	endfunction

	function automatic row_t cfg_row(input dphh_pkg::reg_index_t idx,
			input logic [ANGLE_W-1:0] data);
		row_t r;
		r = '{idx: dphh_pkg::REG_TARGET_DISTANCE, default: '0};
		r.is_cfg = 1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	// result side: compare each transfer, then decide the next stall
	always @(posedge clk) begin : result_check
		drive_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_drives.size() == 0) begin
				$error("drive result transfer with nothing pending");
				fail_count++;
			end else begin
				want = pending_drives.pop_front();
				if (left_drive_mv !== want.left) begin
					$error("left_drive_mv: expected %0d, actual %0d", want.left, left_drive_mv);
					fail_count++;
				end
				if (right_drive_mv !== want.right) begin
					$error("right_drive_mv: expected %0d, actual %0d", want.right,
						right_drive_mv);
					fail_count++;
				end
				if (move_done !== want.done) begin
					$error("move_done: expected %0b, actual %0b", want.done, move_done);
					fail_count++;
				end
				if (drive_saturated !== want.sat) begin
					$error("drive_saturated: expected %0b, actual %0b", want.sat,
						drive_saturated);
					fail_count++;
				end
			end
			results_checked++;
			if (move_done === 1'b1)
				done_seen++;
			if (drive_saturated === 1'b1)
				sat_seen++;
		end
		// long hold-off once armed, random stalls otherwise
		if (hold_armed && hold_count < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_count++;
		end else begin
			out_stall <= !recv_calm && (int'($urandom_range(0, 99)) < 38);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin : stimulus
		row_t plan[$];
		drive_result_t none;
		logic [ANGLE_W-1:0] tv, hv, kv, wv;
		int k;
		none = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		plan.push_back(known_row(dphh_pkg::OP_TICK, 0, 0, 0, 1100, 1100, 0, 0));
		plan.push_back(known_row(dphh_pkg::OP_START, -524288, 524287, -1, 0, 0, 0, 0));
		plan.push_back(known_row(dphh_pkg::OP_TICK, 0, 0, -524288, 32767, -32768, 0, 1));
		plan.push_back(known_row(dphh_pkg::OP_TICK, 0, 0, 524287, -32768, 32767, 0, 1));
		plan.push_back(known_row(dphh_pkg::OP_START, 524287, -524288, 0, 0, 0, 0, 0));
		plan.push_back(cfg_row(dphh_pkg::REG_TARGET_DISTANCE, 20'h7FFFF));
		plan.push_back(item_row(dphh_pkg::OP_TICK, -524288, 524287, 0));
		plan.push_back(item_row(dphh_pkg::OP_TICK, 524287, -524288, -1));
		plan.push_back(cfg_row(dphh_pkg::REG_TARGET_DISTANCE, 20'h80000));
		plan.push_back(item_row(dphh_pkg::OP_TICK, -524288, -524288, 524287));
		plan.push_back(item_row(dphh_pkg::OP_TICK, 1, -1, 0));
		// integral band edges: exactly 150 deg, just inside, just above
		plan.push_back(cfg_row(dphh_pkg::REG_TARGET_DISTANCE, 20'd2400));
		plan.push_back(item_row(dphh_pkg::OP_START, 0, 0, 0));
		plan.push_back(item_row(dphh_pkg::OP_TICK, 0, 0, 0));
		plan.push_back(item_row(dphh_pkg::OP_TICK, -1, 1, 0));
		plan.push_back(cfg_row(dphh_pkg::REG_TARGET_DISTANCE, 20'd2401));
		plan.push_back(item_row(dphh_pkg::OP_TICK, 0, 0, 0));
		// error equal to the window, then just inside
		plan.push_back(cfg_row(dphh_pkg::REG_TARGET_DISTANCE, 20'd16));
		plan.push_back(item_row(dphh_pkg::OP_START, 0, 0, 0));
		plan.push_back(item_row(dphh_pkg::OP_TICK, 0, 0, 0));
		plan.push_back(item_row(dphh_pkg::OP_TICK, 1, -1, 0));
		// zero threshold gives done without settling
		plan.push_back(cfg_row(dphh_pkg::REG_SETTLE_TICKS, 20'd0));
		plan.push_back(item_row(dphh_pkg::OP_TICK, 40, -40, 0));
		plan.push_back(cfg_row(dphh_pkg::REG_HEADING_TARGET, 20'h80000));
		plan.push_back(item_row(dphh_pkg::OP_TICK, 0, 0, 0));
		plan.push_back(cfg_row(dphh_pkg::REG_SETTLE_WINDOW, 20'd0));
		plan.push_back(item_row(dphh_pkg::OP_TICK, 16, 16, 0));
		plan.push_back(cfg_row(dphh_pkg::REG_SETTLE_WINDOW, 20'hFFFF));
		plan.push_back(cfg_row(dphh_pkg::REG_SETTLE_TICKS, 20'hFF));
		plan.push_back(cfg_row(dphh_pkg::REG_HEADING_TARGET, 20'h7FFFF));
		plan.push_back(item_row(dphh_pkg::OP_TICK, -3, 5, 524287));

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].data);
			else
				send_item(plan[i].op, plan[i].a, plan[i].b, plan[i].g, plan[i].typed,
					plan[i].res);
		end

		// receiver holds off while the sender keeps offering
		set_config(ANGLE_W'($urandom_range(2000, 9000)), 0, 10, 16);
		send_calm = 1;
		hold_armed = 1;
		run_move(20);
		send_calm = 0;

		// a stretch with no idling on either side
		send_calm = 1;
		recv_calm = 1;
		run_move(20);
		send_calm = 0;
		recv_calm = 0;

		// counters and ramp run up to their ceilings
		set_config(0, 0, 255, 20'hFFFF);
		send_item(dphh_pkg::OP_START, 0, 0, 0, 0, none);
		for (k = 0; k < 300; k++)
			send_item(dphh_pkg::OP_TICK, to_angle(int'($urandom_range(0, 4000)) - 2000),
				to_angle(int'($urandom_range(0, 4000)) - 2000),
				to_angle(int'($urandom_range(0, 400)) - 200), 0, none);

		// mixed settings, extremes among them
		while (ticks_sent + starts_sent < ITEM_GOAL) begin
			case ($urandom_range(0, 5))
				0: tv = 20'h80000;
				1: tv = 20'h7FFFF;
				2: tv = ANGLE_W'($urandom);
				default: tv = ANGLE_W'($urandom_range(0, 12000));
			endcase
			hv = ($urandom_range(0, 3) == 0) ? ANGLE_W'($urandom) : to_angle(
				int'($urandom_range(0, 400)) - 200);
			case ($urandom_range(0, 3))
				0: kv = 0;
				1: kv = 255;
				default: kv = ANGLE_W'($urandom_range(1, 20));
			endcase
			case ($urandom_range(0, 3))
				0: wv = 0;
				1: wv = 20'hFFFF;
				default: wv = ANGLE_W'($urandom_range(4, 200));
			endcase
			set_config(tv, hv, kv, wv);
			repeat ($urandom_range(2, 4)) run_move($urandom_range(10, 30));
		end

		// drain
		in_valid <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("sent %0d ticks and %0d starts over reset, extreme and random settings",
			ticks_sent, starts_sent);
		$display("checked %0d results: %0d with move done, %0d saturated", results_checked,
			done_seen, sat_seen);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
